// File: rtl/int8_conv_quad_mac_scale_top_macros.svh
// ---------------------------------------------------------------------------
// int8_conv_quad_mac_scale_top_macros
// Assertion macros shared by the tap engine RTL; clocked on clk, off in rst.
// ---------------------------------------------------------------------------
`ifndef INT8_CONV_QUAD_MAC_SCALE_TOP_MACROS_SVH
`define INT8_CONV_QUAD_MAC_SCALE_TOP_MACROS_SVH

// same-cycle implication
`define ICQMS_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("icqms: same-cycle check failed");

// next-cycle implication
`define ICQMS_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("icqms: next-cycle check failed");

`endif

// File: rtl/icqms_pkg.sv
// ---------------------------------------------------------------------------
// icqms_pkg
// Types and constants of the int8 four-channel convolution tap engine.
// ---------------------------------------------------------------------------
package icqms_pkg;

  localparam int SUM_WIDTH_DEF = 32;
  localparam int LANES         = 4;
  localparam int CFG_IDX_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_CH0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_CH1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_CH2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_CH3 = 8'd3;

  localparam logic signed [31:0] SCALE_ONE = 32'sd65536;

  typedef struct packed {
    logic [31:0] source_quad;
    logic [63:0] weights_low;
    logic [63:0] weights_high;
    logic        last_tap;
  } icqms_in_t;

  typedef struct packed {
    logic signed [31:0] out_ch3;
    logic signed [31:0] out_ch2;
    logic signed [31:0] out_ch1;
    logic signed [31:0] out_ch0;
  } icqms_out_t;

  typedef struct packed {
    logic acc_en;
    logic last;
    logic mul_lo;
    logic mul_hi;
  } icqms_ctl_t;

  typedef enum logic [1:0] {
    SCL_IDLE,
    SCL_LO,
    SCL_HI,
    SCL_OUT
  } scl_state_t;

endpackage

// File: rtl/int8_conv_quad_mac_scale_top.sv
// ---------------------------------------------------------------------------
// int8_conv_quad_mac_scale_top
// Four-output-channel int8 convolution tap engine with per-channel Q16.16
// output scaling and 32-bit saturation.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   tap     | tap_valid / tap_ready  | tap_data (source quad, weights, last)
//   result  | res_valid / res_ready  | res_data (four scaled channel sums)
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (scale registers)
//
// Taps that are not last are taken every cycle, also while a result is being
// scaled. A last tap is taken only when the scaler is idle; scaling then goes
// through a low product, a high product and a combine step on the lane multiplier,
// and the result enters the output register in the combine step once it is free.
// Sustained rate: one tap per cycle, but a last tap waits while the scaler is busy.
// Synchronous reset clears accumulators and result valid, and sets scales to 1.0.
// ---------------------------------------------------------------------------
`include "int8_conv_quad_mac_scale_top_macros.svh"

module int8_conv_quad_mac_scale_top #(
  parameter int SUM_WIDTH = icqms_pkg::SUM_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tap_valid,
  output logic                            tap_ready,
  input  icqms_pkg::icqms_in_t            tap_data,
  output logic                            res_valid,
  input  logic                            res_ready,
  output icqms_pkg::icqms_out_t           res_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [icqms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);
  import icqms_pkg::*;

  scl_state_t         state;
  scl_state_t         state_next;
  logic signed [31:0] scale [LANES];
  logic [3:0][31:0]   lane_wts;
  logic [3:0][31:0]   lane_res;
  icqms_ctl_t         ctl;
  logic               tap_acc;
  logic               out_free;
  logic               res_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LANES; k++) begin
        scale[k] <= SCALE_ONE;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCALE_CH0: scale[0] <= $signed(cfg_data);
        CFG_SCALE_CH1: scale[1] <= $signed(cfg_data);
        CFG_SCALE_CH2: scale[2] <= $signed(cfg_data);
        CFG_SCALE_CH3: scale[3] <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign tap_acc  = tap_valid && tap_ready;
  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SCL_IDLE: if (tap_acc && tap_data.last_tap) state_next = SCL_LO;
      SCL_LO:   state_next = SCL_HI;
      SCL_HI:   state_next = SCL_OUT;
      SCL_OUT:  if (out_free) state_next = SCL_IDLE;
      default:  state_next = SCL_IDLE;
    endcase
  end

  always_comb begin
    tap_ready  = (state == SCL_IDLE) || !tap_data.last_tap;
    ctl.acc_en = tap_acc;
    ctl.last   = tap_data.last_tap;
    ctl.mul_lo = (state == SCL_LO);
    ctl.mul_hi = (state == SCL_HI);
    res_load   = (state == SCL_OUT) && out_free;
  end

  // route weight byte 4*row+outch of each row to lane outch
  for (genvar o = 0; o < LANES; o++) begin : g_lane
    for (genvar i = 0; i < 4; i++) begin : g_row
      if (i < 2) begin : g_lo
        assign lane_wts[o][8*i +: 8] = tap_data.weights_low[8*(4*i+o) +: 8];
      end else begin : g_hi
        assign lane_wts[o][8*i +: 8] = tap_data.weights_high[8*(4*(i-2)+o) +: 8];
      end
    end

    icqms_lane #(
      .SUM_WIDTH(SUM_WIDTH)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .src   (tap_data.source_quad),
      .wts   (lane_wts[o]),
      .scale (scale[o]),
      .result(lane_res[o])
    );
  end

  icqms_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .lane_res (lane_res),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  `ICQMS_AST_IMP(a_last_only_idle, tap_acc && tap_data.last_tap, state == SCL_IDLE)
  `ICQMS_AST_NXT(a_last_starts_scale, tap_acc && tap_data.last_tap, state == SCL_LO)
  `ICQMS_AST_NXT(a_lo_then_hi, state == SCL_LO, state == SCL_HI)
  `ICQMS_AST_IMP(a_load_when_free, res_load, !res_valid || res_ready)
  `ICQMS_AST_NXT(a_load_shows_result, res_load, res_valid)

endmodule

// File: rtl/icqms_lane.sv
// ---------------------------------------------------------------------------
// icqms_lane
// One output channel: 4-term int8 dot product into a saturating accumulator,
// then a two-step Q16.16 scale with rounding and 32-bit saturation.
// ---------------------------------------------------------------------------
module icqms_lane #(
  parameter int SUM_WIDTH = icqms_pkg::SUM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  icqms_pkg::icqms_ctl_t ctl,
  input  logic [31:0]           src,
  input  logic [31:0]           wts,
  input  logic signed [31:0]    scale,
  output logic signed [31:0]    result
);
  import icqms_pkg::*;

  localparam int HW   = SUM_WIDTH - 16;
  localparam int MW   = (HW > 16) ? HW : 16;
  localparam int PW   = MW + 32;
  localparam int MAGW = PW + 1;

  logic signed [15:0]          prod [4];
  logic signed [17:0]          tap_sum;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic [SUM_WIDTH-1:0]        acc_sat;
  logic signed [SUM_WIDTH-1:0] acc;
  logic [SUM_WIDTH-1:0]        mag_a;
  logic                        neg_a;
  logic [31:0]                 scale_u;
  logic [MW-1:0]               op_a;
  logic [PW-1:0]               mul;
  logic [47:0]                 plo;
  logic [PW-1:0]               phi;
  logic [47:0]                 plo_rnd;
  logic [MAGW-1:0]             mag;
  logic                        neg;
  logic [31:0]                 lim;
  logic [31:0]                 mag_c;

  always_comb begin
    tap_sum = '0;
    for (int i = 0; i < 4; i++) begin
      prod[i] = $signed(src[8*i +: 8]) * $signed(wts[8*i +: 8]);
      tap_sum = tap_sum + 18'(prod[i]);
    end
  end

  always_comb begin
    sum_wide = $signed({acc[SUM_WIDTH-1], acc}) + (SUM_WIDTH+1)'(tap_sum);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      acc_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      acc_sat = sum_wide[SUM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= ctl.last ? '0 : $signed(acc_sat);
    end
  end

  // hold the finished pixel sum as sign and magnitude
  always_ff @(posedge clk) begin
    if (ctl.acc_en && ctl.last) begin
      mag_a <= acc_sat[SUM_WIDTH-1] ? (~acc_sat + SUM_WIDTH'(1)) : acc_sat;
      neg_a <= acc_sat[SUM_WIDTH-1];
    end
  end

  assign scale_u = scale[31] ? (~scale + 32'd1) : scale;
  assign op_a    = ctl.mul_hi ? MW'(mag_a[SUM_WIDTH-1:16]) : MW'(mag_a[15:0]);
  assign mul     = PW'(op_a) * PW'(scale_u);

  always_ff @(posedge clk) begin
    if (ctl.mul_lo) begin
      plo <= mul[47:0];
    end
    if (ctl.mul_hi) begin
      phi <= mul;
    end
  end

  always_comb begin
    plo_rnd = plo + 48'h0000_0000_8000;
    mag     = MAGW'(phi) + MAGW'(plo_rnd[47:16]);
    neg     = neg_a ^ scale[31];
    lim     = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag_c   = (mag > MAGW'(lim)) ? lim : mag[31:0];
    result  = neg ? $signed(~mag_c + 32'd1) : $signed(mag_c);
  end

endmodule

// File: rtl/icqms_merge.sv
// ---------------------------------------------------------------------------
// icqms_merge
// Gathers the four lane results into one result item and holds it in the
// output register until the consumer takes it.
// ---------------------------------------------------------------------------
module icqms_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [3:0][31:0]      lane_res,
  output logic                  res_valid,
  input  logic                  res_ready,
  output icqms_pkg::icqms_out_t res_data
);
  import icqms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data.out_ch0 <= $signed(lane_res[0]);
      res_data.out_ch1 <= $signed(lane_res[1]);
      res_data.out_ch2 <= $signed(lane_res[2]);
      res_data.out_ch3 <= $signed(lane_res[3]);
    end
  end

endmodule

// File: test/int8_conv_quad_mac_scale_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// int8_conv_quad_mac_scale_top_tb
// Self-checking bench for the four-channel int8 convolution tap engine.
// A directed table covers operand extremes, scale extremes, ignored register
// indexes and rounding ties. Random phases follow, each with its own scale
// setting. An internal model of the accumulators and the Q16.16 scaler checks
// every result item, while both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
module int8_conv_quad_mac_scale_top_tb;
  import icqms_pkg::*;

  localparam int          RAND_ITEMS    = 1950;
  localparam int          RAND_PHASES   = 8;
  localparam int          SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

  typedef enum bit {ROW_TAP, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    icqms_in_t            tap;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
    bit                   has_exp;
    icqms_out_t           exp_res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 tap_valid = 1'b0;
  logic                 tap_ready;
  icqms_in_t            tap_data = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  icqms_out_t           res_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // typed expectation travelling with the tap on the wire
  bit         cur_typed_valid = 1'b0;
  icqms_out_t cur_typed = '0;

  longint             pixel_sums [LANES];
  logic signed [31:0] scale_regs [LANES];
  icqms_out_t         expected_pixels [$];
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        burst_left = 0;
  dir_row_t           directed_rows [$];

  int8_conv_quad_mac_scale_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .tap_data  (tap_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp_sum(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (SUM_WIDTH_DEF - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic [31:0] scale_lane(input longint acc, input logic signed [31:0] scale);
    bit                neg;
    longint            sc;
    longint            r;
    longint unsigned   a;
    longint unsigned   s;
    longint unsigned   hi;
    longint unsigned   lo;
    longint unsigned   mag;
    longint unsigned   lim;
    sc  = longint'(scale);
    neg = (acc < 0) != (sc < 0);
    a   = (acc < 0) ? longint'(-acc) : acc;
    s   = (sc < 0) ? longint'(-sc) : sc;
    hi  = a >> 16;
    lo  = a & 64'hFFFF;
    if (a == 0 || s == 0) return 32'd0;
    if (hi != 0 && s > (64'h8000_0000 / hi) + 1) begin
      mag = '1;
    end else begin
      mag = hi * s + ((lo * s + 64'h8000) >> 16);
    end
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (mag > lim) mag = lim;
    r = neg ? -longint'(mag) : longint'(mag);
    return r[31:0];
  endfunction

  function automatic bit predict_tap(input icqms_in_t t, output icqms_out_t r);
    longint      tap_sum;
    logic [63:0] wword;
    r = '0;
    for (int o = 0; o < LANES; o++) begin
      tap_sum = 0;
      for (int i = 0; i < LANES; i++) begin
        wword = (i < 2) ? t.weights_low : t.weights_high;
        tap_sum += longint'($signed(t.source_quad[8*i +: 8]))
                 * longint'($signed(wword[8*(4*(i % 2) + o) +: 8]));
      end
      pixel_sums[o] = clamp_sum(pixel_sums[o] + tap_sum);
    end
    if (!t.last_tap) return 1'b0;
    for (int o = 0; o < LANES; o++) begin
      r[32*o +: 32] = scale_lane(pixel_sums[o], scale_regs[o]);
      pixel_sums[o] = 0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    icqms_out_t want;
    icqms_out_t pred;
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result item with no expectation pending: %h", res_data);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          for (int k = 0; k < LANES; k++) begin
            if (res_data[32*k +: 32] !== want[32*k +: 32]) begin
              $error("out_ch%0d: expected %0d, actual %0d", k,
                     $signed(want[32*k +: 32]), $signed(res_data[32*k +: 32]));
              error_count++;
            end
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index <= CFG_SCALE_CH3) begin
        scale_regs[cfg_index[1:0]] = cfg_data;
      end
      if (tap_valid && tap_ready) begin
        if (predict_tap(tap_data, pred)) begin
          expected_pixels.push_back(cur_typed_valid ? cur_typed : pred);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned left;
    int unsigned r;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        r = $urandom_range(99);
        if (r < 10) begin
          res_ready = 1'b1;
          left = $urandom_range(200, 50);
        end else if (r < 55) begin
          res_ready = 1'b1;
          left = $urandom_range(6, 1);
        end else if (r < 90) begin
          res_ready = 1'b0;
          left = $urandom_range(3, 1);
        end else begin
          res_ready = 1'b0;
          left = $urandom_range(40, 10);
        end
      end else begin
        left--;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(7);
    case (r)
      0: return 8'h7F;
      1: return 8'h80;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic icqms_in_t rand_tap(input bit last);
    icqms_in_t t;
    for (int k = 0; k < 4; k++) t.source_quad[8*k +: 8] = rand_byte();
    for (int k = 0; k < 8; k++) begin
      t.weights_low[8*k +: 8]  = rand_byte();
      t.weights_high[8*k +: 8] = rand_byte();
    end
    t.last_tap = last;
    return t;
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return SCALE_ONE;
      4: return -SCALE_ONE;
      5, 6: return $urandom;
      default: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
    endcase
  endfunction

  function automatic dir_row_t mk_tap(input logic [31:0] src, input logic [63:0] wlo,
                                      input logic [63:0] whi, input bit last,
                                      input bit has_exp = 1'b0,
                                      input int e0 = 0, input int e1 = 0,
                                      input int e2 = 0, input int e3 = 0);
    dir_row_t row;
    row.kind    = ROW_TAP;
    row.tap     = '{source_quad: src, weights_low: wlo, weights_high: whi, last_tap: last};
    row.idx     = '0;
    row.data    = '0;
    row.has_exp = has_exp;
    row.exp_res = '{out_ch3: e3, out_ch2: e2, out_ch1: e1, out_ch0: e0};
    return row;
  endfunction

  function automatic dir_row_t mk_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    dir_row_t row;
    row         = mk_tap('0, '0, '0, 1'b0);
    row.kind    = ROW_CFG;
    row.idx     = idx;
    row.data    = data;
    return row;
  endfunction

  task automatic send_tap(input icqms_in_t t, input bit typed = 1'b0,
                          input icqms_out_t typed_res = '0);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(99);
      if (r < 50)      gap = 0;
      else if (r < 85) gap = $urandom_range(3, 1);
      else if (r < 95) gap = $urandom_range(8, 4);
      else             gap = $urandom_range(40, 10);
      if ($urandom_range(63) == 0) burst_left = $urandom_range(150, 50);
    end
    if (gap > 0) begin
      tap_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tap_valid       = 1'b1;
    tap_data        = t;
    cur_typed_valid = typed;
    cur_typed       = typed_res;
    @(posedge clk);
    while (!tap_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    tap_valid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    row_kind_t prev_kind;
    int        items;
    int        len;
    int        r;
    int        per_phase;

    for (int k = 0; k < LANES; k++) begin
      pixel_sums[k] = 0;
      scale_regs[k] = SCALE_ONE;
    end

    // zero tap straight after reset, then operand extremes at scale 1.0
    directed_rows.push_back(mk_tap(32'h0, 64'h0, 64'h0, 1'b1, 1'b1, 0, 0, 0, 0));
    directed_rows.push_back(mk_tap(32'h7F7F7F7F, {2{32'h7F7F7F7F}}, {2{32'h7F7F7F7F}},
                                   1'b1, 1'b1, 64516, 64516, 64516, 64516));
    directed_rows.push_back(mk_tap(32'h80808080, {2{32'h80808080}}, {2{32'h80808080}},
                                   1'b1, 1'b1, 65536, 65536, 65536, 65536));
    directed_rows.push_back(mk_tap(32'h80808080, {2{32'h7F7F7F7F}}, {2{32'h7F7F7F7F}},
                                   1'b1, 1'b1, -65024, -65024, -65024, -65024));
    directed_rows.push_back(mk_tap(32'hFFFFFFFF, {2{32'h01010101}}, {2{32'h01010101}}, 1'b0));
    directed_rows.push_back(mk_tap(32'h01010101, {2{32'h7F7F7F7F}}, {2{32'h7F7F7F7F}}, 1'b1));
    directed_rows.push_back(mk_tap(32'h04030201, 64'h0123456789ABCDEF,
                                   64'hFEDCBA9876543210, 1'b1));
    // scale extremes and ignored indexes
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH0, 32'h7FFF_FFFF));
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH1, 32'h8000_0000));
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH2, 32'h0));
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH3, -SCALE_ONE));
    directed_rows.push_back(mk_cfg(CFG_UNUSED_LO, 32'h0));
    directed_rows.push_back(mk_cfg(CFG_UNUSED_HI, 32'h0));
    directed_rows.push_back(mk_tap(32'h80808080, {2{32'h80808080}}, {2{32'h80808080}}, 1'b0));
    directed_rows.push_back(mk_tap(32'h80808080, {2{32'h80808080}}, {2{32'h80808080}},
                                   1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 0, -131072));
    directed_rows.push_back(mk_tap(32'h80808080, {2{32'h7F7F7F7F}}, {2{32'h7F7F7F7F}}, 1'b1));
    // half scale: ties round away from zero
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH0, 32'h8000));
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH1, 32'h8000));
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH2, 32'h8000));
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH3, 32'h8000));
    directed_rows.push_back(mk_tap(32'h00000001, 64'h00000000FD03FF01, 64'h0,
                                   1'b1, 1'b1, 1, -1, 2, -2));
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH0, SCALE_ONE));
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH1, SCALE_ONE));
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH2, SCALE_ONE));
    directed_rows.push_back(mk_cfg(CFG_SCALE_CH3, SCALE_ONE));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    prev_kind = ROW_TAP;
    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_CFG) begin
        if (prev_kind == ROW_TAP) wait_idle();
        write_cfg(directed_rows[n].idx, directed_rows[n].data);
      end else begin
        if (prev_kind == ROW_CFG) cfg_valid = 1'b0;
        send_tap(directed_rows[n].tap, directed_rows[n].has_exp, directed_rows[n].exp_res);
      end
      prev_kind = directed_rows[n].kind;
    end
    cfg_valid = 1'b0;

    per_phase = RAND_ITEMS / RAND_PHASES;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      for (int c = 0; c < LANES; c++) write_cfg(CFG_SCALE_CH0 + CFG_IDX_W'(c), pick_scale());
      if ($urandom_range(3) == 0) begin
        write_cfg(CFG_IDX_W'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)), $urandom);
      end
      cfg_valid = 1'b0;
      items = 0;
      while (items < per_phase) begin
        r = $urandom_range(99);
        if (r < 70)      len = $urandom_range(4, 1);
        else if (r < 95) len = $urandom_range(16, 5);
        else             len = $urandom_range(64, 17);
        for (int k = 0; k < len; k++) send_tap(rand_tap(k == len - 1));
        items += len;
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
